// ===== sv/obstacle_avoid_drive_sequencer_top_assert.svh =====
// ============================================================================
// obstacle avoid drive sequencer assertion macros
// clocked property wrappers used by the sequencer top level
// ============================================================================
`ifndef OBSTACLE_AVOID_DRIVE_SEQUENCER_TOP_ASSERT_SVH
`define OBSTACLE_AVOID_DRIVE_SEQUENCER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every clk edge outside reset
`define OADS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oads assertion failed");

// next-cycle implication, checked on every clk edge outside reset
`define OADS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oads assertion failed");

`else

`define OADS_ASSERT_SAME(lbl, ante, cons)
`define OADS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/oads_pkg.sv =====
// ============================================================================
// oads_pkg
// shared types and constants of the obstacle avoid drive sequencer
// ============================================================================
package oads_pkg;

    // apb address width: eight 32-bit registers
    localparam int unsigned ADDR_BITS = 5;
    localparam int unsigned DATA_BITS = 32;

    // register reset values
    localparam int unsigned FAR_RESET         = 15;
    localparam int unsigned NEAR_RESET        = 4;
    localparam int unsigned STOP_RESET        = 300;
    localparam int unsigned REVERSE_RESET     = 600;
    localparam int unsigned CHECK_LEFT_RESET  = 500;
    localparam int unsigned CHECK_RIGHT_RESET = 700;
    localparam int unsigned TURN_RESET        = 700;
    localparam int unsigned TIMEOUT_RESET     = 10000;

    // shortest distance sample that is kept
    localparam int unsigned MIN_VALID_CM = 2;

    localparam logic [8:0]  DUTY_ZERO    = 9'd0;
    localparam logic [8:0]  DUTY_SLOW    = 9'd150;
    localparam logic [8:0]  DUTY_FAST    = 9'd300;
    localparam logic [12:0] SERVO_LEFT   = 13'd3125;
    localparam logic [12:0] SERVO_CENTER = 13'd5050;
    localparam logic [12:0] SERVO_RIGHT  = 13'd6250;

    typedef enum logic [2:0] {
        REG_FAR         = 3'd0,
        REG_NEAR        = 3'd1,
        REG_STOP        = 3'd2,
        REG_REVERSE     = 3'd3,
        REG_CHECK_LEFT  = 3'd4,
        REG_CHECK_RIGHT = 3'd5,
        REG_TURN        = 3'd6,
        REG_TIMEOUT     = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_FWD    = 3'd1,
        ST_STOP   = 3'd2,
        ST_REV    = 3'd3,
        ST_CHKL   = 3'd4,
        ST_CHKR   = 3'd5,
        ST_TURNL  = 3'd6,
        ST_TURNR  = 3'd7
    } drive_state_t;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } motor_dir_t;

    // one result word
    typedef struct packed {
        logic         autonomous;
        drive_state_t state;
        motor_dir_t   dir;
        logic [8:0]   duty;
        logic [12:0]  servo;
    } result_t;

endpackage

// ===== sv/oads_cfg.sv =====
// ============================================================================
// oads_cfg
// apb register file holding thresholds, dwell times and the manual timeout
// ============================================================================
module oads_cfg
    import oads_pkg::*;
#(
    parameter int unsigned DISTANCE_BITS = 10,
    parameter int unsigned TIMER_BITS    = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [DATA_BITS-1:0]     pwdata,
    output logic [DATA_BITS-1:0]     prdata,
    output logic                     pready,
    output logic [DISTANCE_BITS-1:0] far_cm,
    output logic [DISTANCE_BITS-1:0] near_cm,
    output logic [TIMER_BITS-1:0]    stop_ms,
    output logic [TIMER_BITS-1:0]    reverse_ms,
    output logic [TIMER_BITS-1:0]    check_left_ms,
    output logic [TIMER_BITS-1:0]    check_right_ms,
    output logic [TIMER_BITS-1:0]    turn_ms,
    output logic [TIMER_BITS-1:0]    timeout_ms
);

    logic [DISTANCE_BITS-1:0] far_reg, near_reg;
    logic [TIMER_BITS-1:0]    stop_reg, reverse_reg, chkl_reg, chkr_reg, turn_reg, timeout_reg;
    logic                     wr_en;
    cfg_reg_t                 sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign sel    = cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_reg     <= DISTANCE_BITS'(FAR_RESET);
            near_reg    <= DISTANCE_BITS'(NEAR_RESET);
            stop_reg    <= TIMER_BITS'(STOP_RESET);
            reverse_reg <= TIMER_BITS'(REVERSE_RESET);
            chkl_reg    <= TIMER_BITS'(CHECK_LEFT_RESET);
            chkr_reg    <= TIMER_BITS'(CHECK_RIGHT_RESET);
            turn_reg    <= TIMER_BITS'(TURN_RESET);
            timeout_reg <= TIMER_BITS'(TIMEOUT_RESET);
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_FAR:         far_reg     <= pwdata[DISTANCE_BITS-1:0];
                REG_NEAR:        near_reg    <= pwdata[DISTANCE_BITS-1:0];
                REG_STOP:        stop_reg    <= pwdata[TIMER_BITS-1:0];
                REG_REVERSE:     reverse_reg <= pwdata[TIMER_BITS-1:0];
                REG_CHECK_LEFT:  chkl_reg    <= pwdata[TIMER_BITS-1:0];
                REG_CHECK_RIGHT: chkr_reg    <= pwdata[TIMER_BITS-1:0];
                REG_TURN:        turn_reg    <= pwdata[TIMER_BITS-1:0];
                REG_TIMEOUT:     timeout_reg <= pwdata[TIMER_BITS-1:0];
                default:         far_reg     <= far_reg;
            endcase
        end
    end

    // read mux, zero extended
    always_comb
    begin
        unique case (sel)
            REG_FAR:         prdata = DATA_BITS'(far_reg);
            REG_NEAR:        prdata = DATA_BITS'(near_reg);
            REG_STOP:        prdata = DATA_BITS'(stop_reg);
            REG_REVERSE:     prdata = DATA_BITS'(reverse_reg);
            REG_CHECK_LEFT:  prdata = DATA_BITS'(chkl_reg);
            REG_CHECK_RIGHT: prdata = DATA_BITS'(chkr_reg);
            REG_TURN:        prdata = DATA_BITS'(turn_reg);
            REG_TIMEOUT:     prdata = DATA_BITS'(timeout_reg);
            default:         prdata = '0;
        endcase
    end

    assign far_cm         = far_reg;
    assign near_cm        = near_reg;
    assign stop_ms        = stop_reg;
    assign reverse_ms     = reverse_reg;
    assign check_left_ms  = chkl_reg;
    assign check_right_ms = chkr_reg;
    assign turn_ms        = turn_reg;
    assign timeout_ms     = timeout_reg;

endmodule

// ===== sv/oads_step.sv =====
// ============================================================================
// oads_step
// one tick of the mode logic and the obstacle avoidance state machine
// ============================================================================
module oads_step
    import oads_pkg::*;
#(
    parameter int unsigned DISTANCE_BITS = 10,
    parameter int unsigned TIMER_BITS    = 16
)
(
    input  logic [DISTANCE_BITS-1:0] far_cm,
    input  logic [DISTANCE_BITS-1:0] near_cm,
    input  logic [TIMER_BITS-1:0]    stop_ms,
    input  logic [TIMER_BITS-1:0]    reverse_ms,
    input  logic [TIMER_BITS-1:0]    check_left_ms,
    input  logic [TIMER_BITS-1:0]    check_right_ms,
    input  logic [TIMER_BITS-1:0]    turn_ms,
    input  logic [TIMER_BITS-1:0]    timeout_ms,
    input  logic [DISTANCE_BITS-1:0] sample,
    input  logic                     present,
    input  logic                     manual,
    input  logic                     mode,
    input  drive_state_t             fsm,
    input  logic [TIMER_BITS-1:0]    ticks,
    input  logic [TIMER_BITS-1:0]    idle_ticks,
    input  logic [DISTANCE_BITS-1:0] last_dist,
    input  logic [12:0]              servo,
    output logic                     mode_next,
    output drive_state_t             fsm_next,
    output logic [TIMER_BITS-1:0]    ticks_next,
    output logic [TIMER_BITS-1:0]    idle_ticks_next,
    output logic [DISTANCE_BITS-1:0] last_dist_next,
    output logic [12:0]              servo_next,
    output result_t                  result
);

    logic [TIMER_BITS-1:0]    ticks_inc, idle_inc;
    logic [DISTANCE_BITS-1:0] cur_cm;
    drive_state_t             fsm_sel;
    motor_dir_t               auto_dir, dir;
    logic [8:0]               auto_duty, duty;
    logic [12:0]              auto_servo;

    // saturating counters
    assign ticks_inc = (ticks == '1) ? ticks : ticks + 1'b1;
    assign idle_inc  = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;

    // short or missing samples keep the old distance
    assign cur_cm = (present && sample >= DISTANCE_BITS'(MIN_VALID_CM)) ? sample : last_dist;

    // autonomous state machine decision
    always_comb
    begin
        fsm_sel    = fsm;
        auto_dir   = DIR_STOP;
        auto_duty  = DUTY_ZERO;
        auto_servo = servo;
        unique case (fsm)
            ST_IDLE:
            begin
                if (cur_cm > far_cm)
                    fsm_sel = ST_FWD;
                else if (cur_cm != '0 && cur_cm <= near_cm)
                    fsm_sel = ST_REV;
            end
            ST_FWD:
            begin
                // near test ahead of far test
                if (cur_cm == '0)
                    fsm_sel = ST_STOP;
                else if (cur_cm <= near_cm)
                    fsm_sel = ST_REV;
                else if (cur_cm <= far_cm)
                begin
                    auto_dir  = DIR_FWD;
                    auto_duty = DUTY_SLOW;
                end
                else
                begin
                    auto_dir  = DIR_FWD;
                    auto_duty = DUTY_FAST;
                end
            end
            ST_STOP:
            begin
                if (ticks >= stop_ms)
                    fsm_sel = ST_REV;
            end
            ST_REV:
            begin
                if (ticks >= reverse_ms)
                    fsm_sel = ST_CHKL;
                else
                begin
                    auto_dir  = DIR_BACK;
                    auto_duty = DUTY_SLOW;
                end
            end
            ST_CHKL:
            begin
                auto_servo = SERVO_LEFT;
                if (ticks >= check_left_ms)
                    fsm_sel = (cur_cm > far_cm) ? ST_TURNL : ST_CHKR;
            end
            ST_CHKR:
            begin
                auto_servo = SERVO_RIGHT;
                if (ticks >= check_right_ms)
                    fsm_sel = (cur_cm > far_cm) ? ST_TURNR : ST_REV;
            end
            ST_TURNL, ST_TURNR:
            begin
                auto_servo = (fsm == ST_TURNL) ? SERVO_LEFT : SERVO_RIGHT;
                auto_dir   = DIR_FWD;
                auto_duty  = DUTY_SLOW;
                if (ticks >= turn_ms)
                begin
                    auto_servo = SERVO_CENTER;
                    fsm_sel    = ST_FWD;
                end
            end
            default:
            begin
                fsm_sel = fsm;
            end
        endcase
    end

    // mode handling
    always_comb
    begin
        mode_next       = mode;
        fsm_next        = fsm;
        ticks_next      = ticks;
        idle_ticks_next = idle_ticks;
        last_dist_next  = last_dist;
        servo_next      = servo;
        dir             = DIR_STOP;
        duty            = DUTY_ZERO;
        priority if (manual)
        begin
            idle_ticks_next = '0;
            mode_next       = 1'b0;
            fsm_next        = ST_IDLE;
            servo_next      = SERVO_CENTER;
        end
        else if (!mode)
        begin
            idle_ticks_next = idle_inc;
            if (idle_inc >= timeout_ms)
            begin
                mode_next  = 1'b1;
                fsm_next   = ST_IDLE;
                ticks_next = '0;
            end
        end
        else
        begin
            last_dist_next = cur_cm;
            servo_next     = auto_servo;
            dir            = auto_dir;
            duty           = auto_duty;
            fsm_next       = fsm_sel;
            ticks_next     = (fsm_sel != fsm) ? '0 : ticks_inc;
        end
    end

    assign result = {mode_next, fsm_next, dir, duty, servo_next};

endmodule

// ===== sv/obstacle_avoid_drive_sequencer_top.sv =====
// ============================================================================
// obstacle_avoid_drive_sequencer_top
// millisecond-tick obstacle avoidance sequencer with manual timeout
// ============================================================================
// pipeline: an accepted item is held in the input register, then its result word in the result register
// throughput: 1 word per cycle while result_stall is low; the combinational step logic closes the state loop
// a stalled result register holds the input register, which then stalls the input
// reset (async, rst_n low): manual mode, idle state, counters and distance cleared,
// servo centered, registers at their reset values, both pipeline stages empty
// ============================================================================
`include "obstacle_avoid_drive_sequencer_top_assert.svh"

module obstacle_avoid_drive_sequencer_top
    import oads_pkg::*;
#(
    parameter int unsigned DISTANCE_BITS = 10,
    parameter int unsigned TIMER_BITS    = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // apb configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [DATA_BITS-1:0]     pwdata,
    output logic [DATA_BITS-1:0]     prdata,
    output logic                     pready,
    // tick item channel
    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic [DISTANCE_BITS-1:0] distance_sample,
    input  logic                     sample_present,
    input  logic                     manual_command,
    // result channel
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic                     autonomous_mode,
    output logic [2:0]               drive_state,
    output logic [1:0]               motor_direction,
    output logic [8:0]               motor_duty,
    output logic [12:0]              servo_duty
);

    // configuration values
    logic [DISTANCE_BITS-1:0] far_cm, near_cm;
    logic [TIMER_BITS-1:0]    stop_ms, reverse_ms, check_left_ms, check_right_ms;
    logic [TIMER_BITS-1:0]    turn_ms, timeout_ms;

    // input register stage
    logic                     s1_valid_reg, s1_valid_next;
    logic [DISTANCE_BITS-1:0] s1_dist_reg;
    logic                     s1_present_reg;
    logic                     s1_manual_reg;
    logic                     s1_load;
    logic                     s1_adv;
    logic                     step_fire;

    // architectural state
    logic                     mode_reg, mode_next;
    drive_state_t             fsm_reg, fsm_next;
    logic [TIMER_BITS-1:0]    ticks_reg, ticks_next;
    logic [TIMER_BITS-1:0]    idle_reg, idle_next;
    logic [DISTANCE_BITS-1:0] dist_reg, dist_next;
    logic [12:0]              servo_reg, servo_next;

    // result register stage
    logic                     res_valid_reg, res_valid_next;
    result_t                  res_reg, res_next;

    oads_cfg #(
        .DISTANCE_BITS (DISTANCE_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .far_cm         (far_cm),
        .near_cm        (near_cm),
        .stop_ms        (stop_ms),
        .reverse_ms     (reverse_ms),
        .check_left_ms  (check_left_ms),
        .check_right_ms (check_right_ms),
        .turn_ms        (turn_ms),
        .timeout_ms     (timeout_ms)
    );

    // handshake: the input register moves on whenever the result register
    // is empty or being taken, so one word a cycle flows when nobody stalls
    assign s1_adv        = ~res_valid_reg | ~result_stall;
    assign item_stall    = s1_valid_reg & ~s1_adv;
    assign s1_load       = item_valid & ~item_stall;
    assign step_fire     = s1_valid_reg & s1_adv;
    assign s1_valid_next = item_stall ? s1_valid_reg : item_valid;
    assign res_valid_next = s1_adv ? s1_valid_reg : res_valid_reg;

    // the step works on the registered item and the current state; the state
    // is written back in the same edge that captures the result word
    oads_step #(
        .DISTANCE_BITS (DISTANCE_BITS),
        .TIMER_BITS    (TIMER_BITS)
    ) u_step (
        .far_cm          (far_cm),
        .near_cm         (near_cm),
        .stop_ms         (stop_ms),
        .reverse_ms      (reverse_ms),
        .check_left_ms   (check_left_ms),
        .check_right_ms  (check_right_ms),
        .turn_ms         (turn_ms),
        .timeout_ms      (timeout_ms),
        .sample          (s1_dist_reg),
        .present         (s1_present_reg),
        .manual          (s1_manual_reg),
        .mode            (mode_reg),
        .fsm             (fsm_reg),
        .ticks           (ticks_reg),
        .idle_ticks      (idle_reg),
        .last_dist       (dist_reg),
        .servo           (servo_reg),
        .mode_next       (mode_next),
        .fsm_next        (fsm_next),
        .ticks_next      (ticks_next),
        .idle_ticks_next (idle_next),
        .last_dist_next  (dist_next),
        .servo_next      (servo_next),
        .result          (res_next)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
            fsm_reg       <= ST_IDLE;
            ticks_reg     <= '0;
            idle_reg      <= '0;
            dist_reg      <= '0;
            servo_reg     <= SERVO_CENTER;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (step_fire)
            begin
                mode_reg  <= mode_next;
                fsm_reg   <= fsm_next;
                ticks_reg <= ticks_next;
                idle_reg  <= idle_next;
                dist_reg  <= dist_next;
                servo_reg <= servo_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_dist_reg    <= distance_sample;
            s1_present_reg <= sample_present;
            s1_manual_reg  <= manual_command;
        end
        if (step_fire)
        begin
            res_reg <= res_next;
        end
    end

    // result word outputs
    assign result_valid    = res_valid_reg;
    assign autonomous_mode = res_reg.autonomous;
    assign drive_state     = res_reg.state;
    assign motor_direction = res_reg.dir;
    assign motor_duty      = res_reg.duty;
    assign servo_duty      = res_reg.servo;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // the input side only stalls behind a full input register
    `OADS_ASSERT_SAME(a_stall_needs_item, item_stall, s1_valid_reg)

    // manual mode never drives the motor
    `OADS_ASSERT_SAME(a_manual_motor_off, result_valid && !autonomous_mode, motor_direction == DIR_STOP && motor_duty == DUTY_ZERO)

    // a manual command yields a manual, idle, centered result word
    `OADS_ASSERT_NEXT(a_manual_cmd_result, step_fire && s1_manual_reg, result_valid && !autonomous_mode && drive_state == ST_IDLE && servo_duty == SERVO_CENTER)

    // stopped motor and zero duty go together
    `OADS_ASSERT_SAME(a_duty_matches_dir, result_valid, (motor_direction == DIR_STOP) == (motor_duty == DUTY_ZERO))

endmodule

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top
// self-checking bench for the obstacle avoid drive sequencer top level
// ----------------------------------------------------------------------------
// tick words are queued by the stimulus process and offered by a clocked
// driver with random gaps; each accepted tick steps a behavioral copy of the
// sequencer, whose result word is queued and compared field by field with
// the words taken by a clocked monitor that stalls at random. registers are
// rewritten over the apb port between phases while the block is drained.
// ============================================================================
module tb_top;
    import oads_pkg::*;

    localparam int DIST_BITS = 10;
    localparam logic [15:0] TIMER_CAP = 16'hFFFF;
    // cycles with no handshake of any kind before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // long receiver hold-off, started once after this many checked words
    localparam int HOLD_OFF_AT = 200;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int MAX_PRINTED = 50;

    // one tick word as offered on the input channel
    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 present;
        logic                 manual;
    } tick_word_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // apb port
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    // tick channel
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    logic [DIST_BITS-1:0] distance_sample = '0;
    logic                 sample_present = 1'b0;
    logic                 manual_command = 1'b0;

    // result channel
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        autonomous_mode;
    logic [2:0]  drive_state;
    logic [1:0]  motor_direction;
    logic [8:0]  motor_duty;
    logic [12:0] servo_duty;

    // register copies kept by the bench
    logic [9:0]  far_cm;
    logic [9:0]  near_cm;
    logic [15:0] stop_ms;
    logic [15:0] reverse_ms;
    logic [15:0] look_left_ms;
    logic [15:0] look_right_ms;
    logic [15:0] turn_ms;
    logic [15:0] timeout_ms;

    // sequencer state as the bench predicts it
    logic         auto_mode;
    drive_state_t cur_state;
    logic [15:0]  dwell_count;
    logic [15:0]  idle_count;
    logic [9:0]   held_distance;
    logic [12:0]  servo_hold;

    // stimulus and scoreboard
    tick_word_t pending_ticks[$];
    result_t    predicted_words[$];
    tick_word_t offered_tick;
    result_t    want_word;
    int ticks_queued = 0;
    int ticks_accepted = 0;
    int words_checked = 0;
    int mismatches = 0;

    // driver and monitor pacing
    int gap_left = 0;
    bit steady_send = 1'b0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit steady_take = 1'b0;

    obstacle_avoid_drive_sequencer_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .distance_sample (distance_sample),
        .sample_present  (sample_present),
        .manual_command  (manual_command),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .autonomous_mode (autonomous_mode),
        .drive_state     (drive_state),
        .motor_direction (motor_direction),
        .motor_duty      (motor_duty),
        .servo_duty      (servo_duty)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one millisecond tick of the sequencer; updates the predicted state and
    // returns the word the block should give for this tick
    function automatic result_t step_sequencer(input tick_word_t tick);
        result_t      word;
        drive_state_t nxt;
        motor_dir_t   dir;
        logic [8:0]   duty;
        logic [9:0]   d;
        logic [15:0]  elapsed;
        dir = DIR_STOP;
        duty = DUTY_ZERO;
        if (tick.manual)
        begin
            // any command drops back to manual, idle, servo centered
            idle_count = '0;
            auto_mode = 1'b0;
            cur_state = ST_IDLE;
            servo_hold = SERVO_CENTER;
        end
        else if (!auto_mode)
        begin
            if (idle_count != TIMER_CAP)
                idle_count = idle_count + 1'b1;
            // the timeout tick only switches mode, the machine waits a tick
            if (idle_count >= timeout_ms)
            begin
                auto_mode = 1'b1;
                cur_state = ST_IDLE;
                dwell_count = '0;
            end
        end
        else
        begin
            // short readings and ticks without a reading keep the old distance
            if (tick.present && tick.distance >= MIN_VALID_CM)
                held_distance = tick.distance;
            d = held_distance;
            elapsed = dwell_count;
            nxt = cur_state;
            case (cur_state)
                ST_IDLE:
                begin
                    if (d > far_cm)
                        nxt = ST_FWD;
                    else if (d != 0 && d <= near_cm)
                        nxt = ST_REV;
                end
                ST_FWD:
                begin
                    // near test before far test: overlap favors reversing
                    if (d == 0)
                        nxt = ST_STOP;
                    else if (d <= near_cm)
                        nxt = ST_REV;
                    else
                    begin
                        dir = DIR_FWD;
                        duty = (d <= far_cm) ? DUTY_SLOW : DUTY_FAST;
                    end
                end
                ST_STOP:
                begin
                    if (elapsed >= stop_ms)
                        nxt = ST_REV;
                end
                ST_REV:
                begin
                    if (elapsed >= reverse_ms)
                        nxt = ST_CHKL;
                    else
                    begin
                        dir = DIR_BACK;
                        duty = DUTY_SLOW;
                    end
                end
                ST_CHKL:
                begin
                    servo_hold = SERVO_LEFT;
                    if (elapsed >= look_left_ms)
                    begin
                        if (d > far_cm)
                            nxt = ST_TURNL;
                        else
                            nxt = ST_CHKR;
                    end
                end
                ST_CHKR:
                begin
                    servo_hold = SERVO_RIGHT;
                    if (elapsed >= look_right_ms)
                    begin
                        if (d > far_cm)
                            nxt = ST_TURNR;
                        else
                            nxt = ST_REV;
                    end
                end
                default:
                begin
                    // turning left or right
                    servo_hold = (cur_state == ST_TURNL) ? SERVO_LEFT : SERVO_RIGHT;
                    dir = DIR_FWD;
                    duty = DUTY_SLOW;
                    if (elapsed >= turn_ms)
                    begin
                        servo_hold = SERVO_CENTER;
                        nxt = ST_FWD;
                    end
                end
            endcase
            // dwell timer clears on a state change, else counts and saturates
            if (nxt != cur_state)
            begin
                cur_state = nxt;
                dwell_count = '0;
            end
            else if (dwell_count != TIMER_CAP)
                dwell_count = dwell_count + 1'b1;
        end
        word.autonomous = auto_mode;
        word.state = cur_state;
        word.dir = dir;
        word.duty = duty;
        word.servo = servo_hold;
        return word;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at word %0d: %s got %0d want %0d",
                     words_checked, what, got, want);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FAR:         far_cm = value[9:0];
            REG_NEAR:        near_cm = value[9:0];
            REG_STOP:        stop_ms = value[15:0];
            REG_REVERSE:     reverse_ms = value[15:0];
            REG_CHECK_LEFT:  look_left_ms = value[15:0];
            REG_CHECK_RIGHT: look_right_ms = value[15:0];
            REG_TURN:        turn_ms = value[15:0];
            default:         timeout_ms = value[15:0];
        endcase
    endtask

    task automatic apply_settings(input int far, input int near, input int stop,
                                  input int rev, input int left, input int right,
                                  input int turn, input int timeout);
        write_register(REG_FAR, far);
        write_register(REG_NEAR, near);
        write_register(REG_STOP, stop);
        write_register(REG_REVERSE, rev);
        write_register(REG_CHECK_LEFT, left);
        write_register(REG_CHECK_RIGHT, right);
        write_register(REG_TURN, turn);
        write_register(REG_TIMEOUT, timeout);
    endtask

    task automatic queue_tick(input int distance, input bit present, input bit manual);
        tick_word_t tick;
        tick.distance = DIST_BITS'(distance);
        tick.present = present;
        tick.manual = manual;
        pending_ticks.push_back(tick);
        ticks_queued++;
    endtask

    // mostly well-formed driving: rare commands, readings around the
    // thresholds and close range so the machine walks through its states
    task automatic queue_random_ticks(input int count);
        int pick;
        int range_cm;
        bit present;
        bit manual;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                range_cm = $urandom_range(0, 12);
            else if (pick < 60)
            begin
                range_cm = int'(far_cm) + $urandom_range(0, 6) - 3;
                if (range_cm < 0)
                    range_cm = 0;
                if (range_cm > 1023)
                    range_cm = 1023;
            end
            else if (pick < 85)
                range_cm = $urandom_range(13, 300);
            else
                range_cm = $urandom_range(0, 1023);
            present = ($urandom_range(0, 99) < 85);
            manual = ($urandom_range(0, 39) == 0);
            queue_tick(range_cm, present, manual);
        end
    endtask

    // block is idle once every queued tick was taken and every word came back
    task automatic wait_drained();
        while (ticks_accepted != ticks_queued || predicted_words.size() != 0)
            @(posedge clk);
        // two register stages in the block
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued ticks, holds a stalled word, random gaps between
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : tick_driver
        int pick;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!(item_valid && item_stall))
        begin
            // word accepted at this edge: step the prediction with it
            if (item_valid)
            begin
                predicted_words.push_back(step_sequencer(offered_tick));
                ticks_accepted++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (pending_ticks.size() != 0)
            begin
                offered_tick = pending_ticks.pop_front();
                distance_sample <= offered_tick.distance;
                sample_present <= offered_tick.present;
                manual_command <= offered_tick.manual;
                item_valid <= 1'b1;
                // gap after this word: mostly none or short, a few long,
                // and stretches of back-to-back words
                pick = $urandom_range(0, 99);
                if (steady_send || pick < 60)
                    gap_left = 0;
                else if (pick < 90)
                    gap_left = $urandom_range(1, 3);
                else
                    gap_left = $urandom_range(5, 25);
                if ($urandom_range(0, 39) == 0)
                    steady_send = !steady_send;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: takes result words, checks them, drives a random stall
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : word_monitor
        int pick;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_words.size() == 0)
                    report_mismatch("word with none predicted, drive_state", drive_state, 0);
                else
                begin
                    want_word = predicted_words.pop_front();
                    if (autonomous_mode !== want_word.autonomous)
                        report_mismatch("autonomous_mode", autonomous_mode,
                                        want_word.autonomous);
                    if (drive_state !== want_word.state)
                        report_mismatch("drive_state", drive_state, want_word.state);
                    if (motor_direction !== want_word.dir)
                        report_mismatch("motor_direction", motor_direction, want_word.dir);
                    if (motor_duty !== want_word.duty)
                        report_mismatch("motor_duty", motor_duty, want_word.duty);
                    if (servo_duty !== want_word.servo)
                        report_mismatch("servo_duty", servo_duty, want_word.servo);
                end
                words_checked++;
            end
            // one long hold-off so both stages fill and the input stalls
            if (!hold_done && words_checked >= HOLD_OFF_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (steady_take || pick < 70)
                    result_stall <= 1'b0;
                else
                begin
                    // this cycle stalls too, so count it off the length
                    if (pick < 95)
                        stall_left = $urandom_range(1, 3) - 1;
                    else
                        stall_left = $urandom_range(8, 30) - 1;
                    result_stall <= 1'b1;
                end
                if ($urandom_range(0, 99) == 0)
                    steady_take = !steady_take;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends a run that has stopped moving
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus: directed ticks, then random phases under several settings
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int far;
        // register copies and predicted state at their reset values
        far_cm = FAR_RESET;
        near_cm = NEAR_RESET;
        stop_ms = STOP_RESET;
        reverse_ms = REVERSE_RESET;
        look_left_ms = CHECK_LEFT_RESET;
        look_right_ms = CHECK_RIGHT_RESET;
        turn_ms = TURN_RESET;
        timeout_ms = TIMEOUT_RESET;
        auto_mode = 1'b0;
        cur_state = ST_IDLE;
        dwell_count = '0;
        idle_count = '0;
        held_distance = '0;
        servo_hold = SERVO_CENTER;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: long timeout, so only manual behavior shows
        queue_tick(0, 1'b0, 1'b0);
        queue_tick(1023, 1'b1, 1'b1);
        queue_tick(1, 1'b1, 1'b0);
        wait_drained();

        // short dwells and timeout to walk the machine by hand
        apply_settings(15, 4, 3, 4, 2, 3, 3, 2);
        queue_tick(1023, 1'b0, 1'b0);       // timeout tick, reading absent
        queue_tick(1, 1'b1, 1'b0);          // reading too short, ignored
        queue_tick(0, 1'b1, 1'b0);          // zero reading, ignored
        queue_tick(3, 1'b1, 1'b0);          // close obstacle from idle: reverse
        repeat (5) queue_tick(3, 1'b1, 1'b0);   // reverse dwell into look left
        repeat (3) queue_tick(100, 1'b1, 1'b0); // left is clear: turn left
        repeat (4) queue_tick(100, 1'b1, 1'b0); // turn dwell into forward
        queue_tick(10, 1'b1, 1'b0);         // between thresholds: slow
        queue_tick(1023, 1'b1, 1'b0);       // clear path: fast
        queue_tick(512, 1'b0, 1'b0);        // no reading, keeps the old one
        queue_tick(2, 1'b1, 1'b0);          // shortest kept reading: reverse
        queue_tick(5, 1'b1, 1'b1);          // command while driving
        wait_drained();

        queue_random_ticks(150);
        wait_drained();

        // all thresholds and dwells at zero
        apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        queue_random_ticks(100);
        wait_drained();

        // thresholds at the top: nothing is ever clear, long dwells
        apply_settings(1023, 1023, 65535, 2, 3, 1, 65535, 0);
        queue_random_ticks(100);
        wait_drained();

        // overlapping thresholds and the longest timeout
        apply_settings(200, 300, 1, 0, 0, 0, 0, 65535);
        queue_random_ticks(60);
        wait_drained();

        repeat (3)
        begin
            far = $urandom_range(5, 400);
            apply_settings(far, $urandom_range(0, far), $urandom_range(0, 8),
                           $urandom_range(0, 8), $urandom_range(0, 8),
                           $urandom_range(0, 8), $urandom_range(0, 8),
                           $urandom_range(0, 6));
            queue_random_ticks(110);
            wait_drained();
        end

        // let any stray word show up before the verdict
        repeat (10) @(posedge clk);
        if (predicted_words.size() != 0)
            report_mismatch("words never received", 0, predicted_words.size());
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/oads_pkg.sv
sv/oads_cfg.sv
sv/oads_step.sv
sv/obstacle_avoid_drive_sequencer_top.sv
tb/sv/tb_top.sv
